// ----- hw/rtl/gdcm_pkg.sv -----
// ----------------------------------------------------------------------------
// gdcm_pkg: grid distance cull shared definitions
// Register indexes, reset values, table and counter sizes.
// ----------------------------------------------------------------------------
package gdcm_pkg;

    localparam int unsigned CELL_ENTRIES = 256;
    localparam int unsigned CELL_AW      = $clog2(CELL_ENTRIES);
    localparam int unsigned FILL_W       = CELL_AW + 1;
    localparam int unsigned CNT_W        = 21;
    localparam int unsigned CFG_AW       = 3;
    localparam int unsigned CFG_DW       = 32;

    localparam logic [CNT_W-1:0] MAX_SLOTS   = 21'd1048576;
    localparam logic [CNT_W-1:0] CNT_LIMIT   = 21'd1048576;
    localparam logic [1:0]       MAX_CAMERAS = 2'd2;

    localparam logic [23:0] CELL_SIZE_RST = 24'd2048;
    localparam logic [23:0] CULL_DIST_RST = 24'd8192;

    typedef enum logic [CFG_AW-1:0] {
        REG_CULL_EN   = 3'd0,
        REG_CELL_SIZE = 3'd1,
        REG_CULL_DIST = 3'd2,
        REG_CAM_CNT   = 3'd3,
        REG_CAM0_X    = 3'd4,
        REG_CAM0_Z    = 3'd5,
        REG_CAM1_X    = 3'd6,
        REG_CAM1_Z    = 3'd7
    } t_reg_idx;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v < CNT_LIMIT) ? v + 1'b1 : CNT_LIMIT;
    endfunction

endpackage

// ----- hw/rtl/grid_distance_cull_mask.sv -----
// ----------------------------------------------------------------------------
// grid_distance_cull_mask: grid cell distance culling, one instance per item
// Flow, accept to result: direct when culling is off, no camera is enabled or the
// slot is skipped; else a bit-serial divide per axis, a probe of the cell table
// (a hit ends the item), then per camera a box check and the shared 27x27 squarer.
// A new item is accepted only once the last result is loaded into the output
// register; a held result stalls the block.
// Reset (synchronous): config to defaults, frame counters and fill cleared.
// ----------------------------------------------------------------------------
module grid_distance_cull_mask (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [gdcm_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [gdcm_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // slot[19:0], slot_limit[40:20], pos_x[72:41], pos_z[104:73]
    input  logic [111:0] s_axis_tdata,
    // frame_first[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_slot[19:0], mask_active[20], slot_valid[21], total_instances[42:22],
    // active_instances[63:43], cells_seen[72:64], cells_active[81:73],
    // table_full[82]
    output logic [87:0]  m_axis_tdata
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DIV   = 13'b0000000000010,
        S_DFIX  = 13'b0000000000100,
        S_SRD   = 13'b0000000001000,
        S_SCMP  = 13'b0000000010000,
        S_R2SQ  = 13'b0000000100000,
        S_CAMD  = 13'b0000001000000,
        S_CHK   = 13'b0000010000000,
        S_SQX   = 13'b0000100000000,
        S_SQZ   = 13'b0001000000000,
        S_CMP   = 13'b0010000000000,
        S_WRITE = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    localparam int unsigned FW = gdcm_pkg::FILL_W;
    localparam int unsigned CW = gdcm_pkg::CNT_W;

    // configuration
    logic               r_cull_en;
    logic [23:0]        r_cell_size;
    logic [23:0]        r_cull_dist;
    logic [1:0]         r_cam_cnt;
    logic signed [31:0] r_cam_x [2];
    logic signed [31:0] r_cam_z [2];

    // control and stats
    t_state          r_state;
    logic [FW-1:0]   r_fill;
    logic [FW-1:0]   r_cell_act;
    logic [CW-1:0]   r_inst_tot;
    logic [CW-1:0]   r_act_tot;
    logic            r_full;
    logic            r_out_valid;
    logic [87:0]     r_out_data;

    // item working registers
    logic [19:0]        r_slot;
    logic signed [31:0] r_px;
    logic signed [31:0] r_pz;
    logic               r_valid;
    logic               r_active;
    logic               r_axis;
    logic [4:0]         r_cnt;
    logic [31:0]        r_dvd;
    logic [23:0]        r_rem;
    logic [31:0]        r_cx;
    logic [31:0]        r_cz;
    logic [23:0]        r_rx;
    logic [23:0]        r_rz;
    logic [FW-1:0]      r_idx;
    logic [64:0]        r_rd;
    logic [25:0]        r_r2;
    logic [52:0]        r_r2sq;
    logic               r_cam;
    logic signed [35:0] r_dx;
    logic signed [35:0] r_dz;
    logic [52:0]        r_prod;
    logic [52:0]        r_sqx;

    logic [64:0] mem [gdcm_pkg::CELL_ENTRIES];

    // input decode
    logic [19:0]        w_slot;
    logic [CW-1:0]      w_count;
    logic signed [31:0] w_px;
    logic signed [31:0] w_pz;
    logic               w_accept;
    logic [1:0]         w_camn;
    logic               w_valid;
    logic               w_out_load;

    assign w_slot   = s_axis_tdata[19:0];
    assign w_count  = (s_axis_tdata[40:20] > gdcm_pkg::MAX_SLOTS) ? gdcm_pkg::MAX_SLOTS
                                                                  : s_axis_tdata[40:20];
    assign w_px     = s_axis_tdata[72:41];
    assign w_pz     = s_axis_tdata[104:73];
    assign w_valid  = {1'b0, w_slot} < w_count;
    assign w_camn   = (r_cam_cnt > gdcm_pkg::MAX_CAMERAS) ? gdcm_pkg::MAX_CAMERAS : r_cam_cnt;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    // divider step
    logic [24:0] w_sh;
    logic        w_ge;
    logic [24:0] w_sub;
    assign w_sh  = {r_rem, r_dvd[31]};
    assign w_ge  = w_sh >= {1'b0, r_cell_size};
    assign w_sub = w_sh - {1'b0, r_cell_size};

    // sign fixup
    logic        w_neg;
    logic        w_rnz;
    logic [31:0] w_q;
    logic [23:0] w_r;
    assign w_neg = r_axis ? r_pz[31] : r_px[31];
    assign w_rnz = (r_rem != 24'd0);
    assign w_q   = w_neg ? (w_rnz ? ~r_dvd : 32'd0 - r_dvd) : r_dvd;
    assign w_r   = (w_neg && w_rnz) ? r_cell_size - r_rem : r_rem;

    logic [31:0] w_abs_z;
    assign w_abs_z = r_pz[31] ? 32'd0 - r_pz : r_pz;

    // camera offsets, doubled
    logic signed [35:0] w_dx;
    logic signed [35:0] w_dz;
    logic signed [35:0] w_r2s;
    logic               w_in;
    assign w_dx = $signed({{3{r_px[31]}}, r_px, 1'b0}) - $signed({11'b0, r_rx, 1'b0})
                + $signed({12'b0, r_cell_size})
                - $signed({{3{r_cam_x[r_cam][31]}}, r_cam_x[r_cam], 1'b0});
    assign w_dz = $signed({{3{r_pz[31]}}, r_pz, 1'b0}) - $signed({11'b0, r_rz, 1'b0})
                + $signed({12'b0, r_cell_size})
                - $signed({{3{r_cam_z[r_cam][31]}}, r_cam_z[r_cam], 1'b0});
    assign w_r2s = $signed({10'b0, r_r2});
    assign w_in  = (r_dx < w_r2s) && (r_dx > -w_r2s) && (r_dz < w_r2s) && (r_dz > -w_r2s);

    // shared squaring multiplier
    logic signed [26:0] w_mul_a;
    logic signed [53:0] w_mul_p;
    always_comb begin
        case (r_state)
            S_R2SQ:  w_mul_a = $signed({1'b0, r_r2});
            S_SQX:   w_mul_a = r_dx[26:0];
            S_SQZ:   w_mul_a = r_dz[26:0];
            default: w_mul_a = 27'sd0;
        endcase
    end
    assign w_mul_p = w_mul_a * w_mul_a;

    logic [53:0] w_sum;
    logic        w_next_cam;
    assign w_sum      = {1'b0, r_sqx} + {1'b0, r_prod};
    assign w_next_cam = ({1'b0, r_cam} + 2'd1) < w_camn;

    logic          w_hit;
    logic          w_we;
    logic [CW-1:0] w_act_n;
    assign w_hit   = (r_rd[63:0] == {r_cx, r_cz});
    assign w_we    = (r_state == S_WRITE) && (r_fill < FW'(gdcm_pkg::CELL_ENTRIES));
    assign w_act_n = (r_valid && r_active) ? gdcm_pkg::sat_inc(r_act_tot) : r_act_tot;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_fill[gdcm_pkg::CELL_AW-1:0]] <= {r_active, r_cx, r_cz};
        end
        r_rd <= mem[r_idx[gdcm_pkg::CELL_AW-1:0]];
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cull_en   <= 1'b1;
            r_cell_size <= gdcm_pkg::CELL_SIZE_RST;
            r_cull_dist <= gdcm_pkg::CULL_DIST_RST;
            r_cam_cnt   <= 2'd0;
            r_cam_x[0]  <= 32'sd0;
            r_cam_z[0]  <= 32'sd0;
            r_cam_x[1]  <= 32'sd0;
            r_cam_z[1]  <= 32'sd0;
        end else if (i_cfg_we) begin
            case (gdcm_pkg::t_reg_idx'(i_cfg_idx))
                gdcm_pkg::REG_CULL_EN:   r_cull_en <= i_cfg_wdata[0];
                gdcm_pkg::REG_CELL_SIZE: begin
                    if (i_cfg_wdata[23:0] != 24'd0) r_cell_size <= i_cfg_wdata[23:0];
                end
                gdcm_pkg::REG_CULL_DIST: begin
                    if (i_cfg_wdata[23:0] != 24'd0) r_cull_dist <= i_cfg_wdata[23:0];
                end
                gdcm_pkg::REG_CAM_CNT:   r_cam_cnt  <= i_cfg_wdata[1:0];
                gdcm_pkg::REG_CAM0_X:    r_cam_x[0] <= i_cfg_wdata;
                gdcm_pkg::REG_CAM0_Z:    r_cam_z[0] <= i_cfg_wdata;
                gdcm_pkg::REG_CAM1_X:    r_cam_x[1] <= i_cfg_wdata;
                gdcm_pkg::REG_CAM1_Z:    r_cam_z[1] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_cell_act  <= '0;
            r_inst_tot  <= '0;
            r_act_tot   <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_slot  <= w_slot;
                        r_px    <= w_px;
                        r_pz    <= w_pz;
                        r_valid <= w_valid;
                        r_axis  <= 1'b0;
                        r_cnt   <= 5'd0;
                        r_rem   <= 24'd0;
                        r_dvd   <= w_px[31] ? 32'd0 - w_px : w_px;
                        r_r2    <= {({1'b0, r_cull_dist} + {1'b0, r_cell_size}), 1'b0};
                        if (s_axis_tuser) begin
                            r_fill     <= '0;
                            r_cell_act <= '0;
                            r_act_tot  <= '0;
                            r_full     <= 1'b0;
                            r_inst_tot <= gdcm_pkg::sat_inc('0);
                        end else begin
                            r_inst_tot <= gdcm_pkg::sat_inc(r_inst_tot);
                        end
                        if (!w_valid) begin
                            r_active <= 1'b0;
                            r_state  <= S_OUT;
                        end else if (!r_cull_en || w_camn == 2'd0) begin
                            r_active <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_state  <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_sub[23:0] : w_sh[23:0];
                    r_dvd <= {r_dvd[30:0], w_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_state <= S_DFIX;
                end
                S_DFIX: begin
                    if (!r_axis) begin
                        r_cx   <= w_q;
                        r_rx   <= w_r;
                        r_axis <= 1'b1;
                        r_dvd  <= w_abs_z;
                        r_rem  <= 24'd0;
                        r_state <= S_DIV;
                    end else begin
                        r_cz   <= w_q;
                        r_rz   <= w_r;
                        r_idx  <= '0;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    if (r_idx >= r_fill) begin
                        r_cam   <= 1'b0;
                        r_state <= S_R2SQ;
                    end else begin
                        r_state <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    if (w_hit) begin
                        r_active <= r_rd[64];
                        r_state  <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_R2SQ: begin
                    r_r2sq  <= w_mul_p[52:0];
                    r_state <= S_CAMD;
                end
                S_CAMD: begin
                    r_dx    <= w_dx;
                    r_dz    <= w_dz;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_in) begin
                        r_state <= S_SQX;
                    end else if (w_next_cam) begin
                        r_cam   <= 1'b1;
                        r_state <= S_CAMD;
                    end else begin
                        r_active <= 1'b0;
                        r_state  <= S_WRITE;
                    end
                end
                S_SQX: begin
                    r_prod  <= w_mul_p[52:0];
                    r_state <= S_SQZ;
                end
                S_SQZ: begin
                    r_sqx   <= r_prod;
                    r_prod  <= w_mul_p[52:0];
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_sum < {1'b0, r_r2sq}) begin
                        r_active <= 1'b1;
                        r_state  <= S_WRITE;
                    end else if (w_next_cam) begin
                        r_cam   <= 1'b1;
                        r_state <= S_CAMD;
                    end else begin
                        r_active <= 1'b0;
                        r_state  <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (w_we) begin
                        r_fill <= r_fill + 1'b1;
                        if (r_active) r_cell_act <= r_cell_act + 1'b1;
                    end else begin
                        r_full <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_act_tot   <= w_act_n;
                        r_out_data  <= {5'd0, r_full, r_cell_act, r_fill, w_act_n, r_inst_tot,
                                        r_valid, r_valid && r_active, r_slot};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(gdcm_pkg::CELL_ENTRIES)) else $error("fill past table size");
    a_cells_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cell_act <= r_fill) else $error("active cells exceed recorded cells");
    a_act_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_tot <= r_inst_tot) else $error("active count exceeds instance count");

endmodule
